[rtl/tsg_pkg.sv]
// shared types, codes and constants of the talkgroup scan gate
package tsg_pkg;

  localparam int unsigned ENTRIES_PER_SLOT_DEF = 16;
  localparam logic [23:0] CLEAR_GROUP = 24'd4000;
  localparam logic [15:0] HOLD_RESET  = 16'd5;
  localparam logic [31:0] NOW_TOP     = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_ADD    = 3'd1,
    REQ_RENEW  = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_CLEAR  = 3'd4,
    REQ_ACCESS = 3'd5,
    REQ_QUERY  = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_SLOT = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  localparam logic [1:0] CFG_SINGLE_MODE  = 2'd0;
  localparam logic [1:0] CFG_HOLD_SECONDS = 2'd1;

  typedef enum logic [3:0] {
    WALK_DROP  = 4'b0001,
    WALK_PURGE = 4'b0010,
    WALK_RENEW = 4'b0100,
    WALK_QUERY = 4'b1000
  } walk_t;

  typedef struct packed {
    logic [23:0] group;
    logic [15:0] lifetime;
    logic [32:0] deadline;
    logic        fixed;
  } entry_t;

  typedef struct packed {
    logic        expired;
    logic        group_hit;
    logic        scan_hit;
    logic [32:0] new_deadline;
  } eval_t;

endpackage

[rtl/tsg_ifs.sv]
// channel interfaces: request, result and configuration write
interface tsg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [23:0] group_id;
  logic [1:0]  slot_num;
  logic [15:0] timeout_seconds;
  logic        make_static;
  modport source (output valid, req_type, group_id, slot_num, timeout_seconds,
                  make_static, input ready);
  modport sink (input valid, req_type, group_id, slot_num, timeout_seconds,
                make_static, output ready);
endinterface

interface tsg_out_if;
  logic       valid;
  logic       ready;
  logic       answer;
  logic [1:0] status;
  modport source (output valid, answer, status, input ready);
  modport sink (input valid, answer, status, output ready);
endinterface

interface tsg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/talkgroup_scan_gate.sv]
// top level of the talkgroup scan gate: sequencer, slot state and table walk
//
//  channel | dir | handshake    | payload
//  in_ch   | in  | valid/ready  | req_type, group_id, slot_num, timeout_seconds, make_static
//  out_ch  | out | valid/ready  | answer, status
//  cfg_ch  | in  | valid/ready  | index, data (0 single_mode, 1 hold_seconds)
//
//  one item at a time; tick, clear and bad slot items skip the walk and go to the final state
//  table walks handle each stored entry in a ram read state, then compare and write back
//  access and query walk both slots; walks use the single ram port pair and the one
//  shared compare unit
//  synchronous active low reset empties both tables via fill counts, no clearing pass
//  a result waiting on out_ch stalls the sequencer in its final state; cfg is always ready
module talkgroup_scan_gate #(
  parameter int unsigned ENTRIES_PER_SLOT = tsg_pkg::ENTRIES_PER_SLOT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tsg_in_if.sink    in_ch,
  tsg_out_if.source out_ch,
  tsg_cfg_if.sink   cfg_ch
);
  localparam int unsigned IW = (ENTRIES_PER_SLOT > 1) ? $clog2(ENTRIES_PER_SLOT) : 1;
  localparam int unsigned FW = $clog2(ENTRIES_PER_SLOT + 1);
  localparam int unsigned AW = IW + 1;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam logic [FW-1:0] FILL_MAX = FW'(ENTRIES_PER_SLOT);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_PROC = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  // sequencer and slot state
  state_t          state_r, state_nxt;
  tsg_pkg::walk_t  mode_r, mode_nxt;
  tsg_pkg::req_t   req_r, req_nxt;
  logic [FW-1:0]   fill_r [2];
  logic [FW-1:0]   fill_nxt [2];
  logic [FW-1:0]   rd_r, rd_nxt, wr_r, wr_nxt;
  logic            ws_r, ws_nxt;
  logic [1:0]      hitg_r, hitg_nxt, hits_r, hits_nxt;
  logic            renewed_r, renewed_nxt;
  logic [31:0]     now_r, now_nxt;
  logic [23:0]     scan_r [2];
  logic [23:0]     scan_nxt [2];
  logic [31:0]     hold_r [2];
  logic [31:0]     hold_nxt [2];
  logic            single_r, single_nxt;
  logic [15:0]     holdsec_r, holdsec_nxt;
  logic            ovalid_r, ovalid_nxt;

  // request payload and results
  logic [23:0]     grp_r, grp_nxt;
  logic [1:0]      slotn_r, slotn_nxt;
  logic [15:0]     tmo_r, tmo_nxt;
  logic            stat_r, stat_nxt;
  logic            ans_r, ans_nxt;
  logic [1:0]      sts_r, sts_nxt;
  logic            oans_r, oans_nxt;
  logic [1:0]      osts_r, osts_nxt;

  // ram and compare unit
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  tsg_pkg::entry_t wentry, rentry;
  logic [$bits(tsg_pkg::entry_t)-1:0] rdata;
  tsg_pkg::eval_t  ev;

  // access decision
  logic [23:0]     sc0, sc1;
  logic            gr0, gr1, use1;
  logic            remove, in_go;
  logic            s_in;

  assign raddr  = {ws_r, rd_r[IW-1:0]};
  assign rentry = tsg_pkg::entry_t'(rdata);

  tsg_ram #(
    .WIDTH ($bits(tsg_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  tsg_eval u_eval (
    .entry      (rentry),
    .now        (now_r),
    .req_group  (grp_r),
    .scan_group (scan_r[ws_r]),
    .timeout    (tmo_r),
    .res        (ev)
  );

  // grant rule for one slot, given the scan group left after purge
  function automatic logic grant_f(input logic hit, input logic [23:0] sc,
                                   input logic [23:0] g, input logic [31:0] now,
                                   input logic [31:0] hold, input logic [15:0] hs);
    logic ok;
    begin
      ok = hit;
      if (hit && (sc != 24'd0) && (sc != g) && ((now - hold) < {16'd0, hs})) begin
        ok = 1'b0;
      end
      return ok;
    end
  endfunction

  assign sc0 = (scan_r[0] != 24'd0 && !hits_r[0]) ? 24'd0 : scan_r[0];
  assign sc1 = (scan_r[1] != 24'd0 && !hits_r[1]) ? 24'd0 : scan_r[1];
  assign gr0 = grant_f(hitg_r[0], sc0, grp_r, now_r, hold_r[0], holdsec_r);
  assign gr1 = grant_f(hitg_r[1], sc1, grp_r, now_r, hold_r[1], holdsec_r);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_go        = in_ch.valid && in_ch.ready;
  assign s_in         = in_ch.slot_num[1];
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid  = ovalid_r;
  assign out_ch.answer = oans_r;
  assign out_ch.status = osts_r;

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    req_nxt     = req_r;
    fill_nxt    = fill_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    ws_nxt      = ws_r;
    hitg_nxt    = hitg_r;
    hits_nxt    = hits_r;
    renewed_nxt = renewed_r;
    now_nxt     = now_r;
    scan_nxt    = scan_r;
    hold_nxt    = hold_r;
    single_nxt  = single_r;
    holdsec_nxt = holdsec_r;
    ovalid_nxt  = ovalid_r;
    grp_nxt     = grp_r;
    slotn_nxt   = slotn_r;
    tmo_nxt     = tmo_r;
    stat_nxt    = stat_r;
    ans_nxt     = ans_r;
    sts_nxt     = sts_r;
    oans_nxt    = oans_r;
    osts_nxt    = osts_r;
    we          = 1'b0;
    waddr       = {ws_r, wr_r[IW-1:0]};
    wentry      = rentry;
    remove      = 1'b0;
    use1        = 1'b0;

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tsg_pkg::CFG_SINGLE_MODE:  single_nxt  = cfg_ch.data[0];
        tsg_pkg::CFG_HOLD_SECONDS: holdsec_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    if (out_ch.valid && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          req_nxt     = tsg_pkg::req_t'(in_ch.req_type);
          grp_nxt     = in_ch.group_id;
          slotn_nxt   = in_ch.slot_num;
          tmo_nxt     = in_ch.timeout_seconds;
          stat_nxt    = in_ch.make_static;
          ans_nxt     = 1'b0;
          sts_nxt     = tsg_pkg::STS_OK;
          rd_nxt      = '0;
          wr_nxt      = '0;
          hitg_nxt    = '0;
          hits_nxt    = '0;
          renewed_nxt = 1'b0;
          ws_nxt      = s_in;
          state_nxt   = ST_FIN;
          case (tsg_pkg::req_t'(in_ch.req_type))
            tsg_pkg::REQ_TICK: begin
              if (now_r != tsg_pkg::NOW_TOP) now_nxt = now_r + 32'd1;
            end
            tsg_pkg::REQ_ADD, tsg_pkg::REQ_RENEW, tsg_pkg::REQ_REMOVE: begin
              if (in_ch.slot_num == 2'd0 || in_ch.slot_num == 2'd3) begin
                sts_nxt = tsg_pkg::STS_SLOT;
              end else if (tsg_pkg::req_t'(in_ch.req_type) == tsg_pkg::REQ_ADD &&
                           in_ch.group_id == tsg_pkg::CLEAR_GROUP) begin
                fill_nxt[s_in] = '0;
              end else begin
                state_nxt = ST_RD;
                mode_nxt  = (tsg_pkg::req_t'(in_ch.req_type) == tsg_pkg::REQ_RENEW) ?
                            tsg_pkg::WALK_RENEW : tsg_pkg::WALK_DROP;
                // single mode: the slot keeps only the new static entry
                if (tsg_pkg::req_t'(in_ch.req_type) == tsg_pkg::REQ_ADD && single_r) begin
                  fill_nxt[s_in] = '0;
                  stat_nxt       = 1'b1;
                end
              end
            end
            tsg_pkg::REQ_CLEAR: begin
              fill_nxt[0] = '0;
              fill_nxt[1] = '0;
              scan_nxt[0] = '0;
              scan_nxt[1] = '0;
            end
            tsg_pkg::REQ_ACCESS, tsg_pkg::REQ_QUERY: begin
              if (tsg_pkg::req_t'(in_ch.req_type) == tsg_pkg::REQ_ACCESS &&
                  in_ch.slot_num == 2'd3) begin
                sts_nxt = tsg_pkg::STS_SLOT;
              end else begin
                state_nxt = ST_RD;
                ws_nxt    = 1'b0;
                mode_nxt  = (tsg_pkg::req_t'(in_ch.req_type) == tsg_pkg::REQ_ACCESS) ?
                            tsg_pkg::WALK_PURGE : tsg_pkg::WALK_QUERY;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RD: begin
        if (rd_r != fill_r[ws_r]) begin
          state_nxt = ST_PROC;
        end else begin
          // end of the walk over this slot: packed length is the write pointer
          fill_nxt[ws_r] = wr_r;
          state_nxt      = ST_FIN;
          case (req_r)
            tsg_pkg::REQ_ADD: begin
              if (wr_r >= FILL_MAX) begin
                sts_nxt = tsg_pkg::STS_FULL;
              end else begin
                we              = 1'b1;
                wentry.group    = grp_r;
                wentry.lifetime = tmo_r;
                wentry.deadline = ev.new_deadline;
                wentry.fixed    = stat_r;
                fill_nxt[ws_r]  = wr_r + FW'(1);
              end
            end
            tsg_pkg::REQ_ACCESS, tsg_pkg::REQ_QUERY: begin
              if (!ws_r) begin
                ws_nxt    = 1'b1;
                rd_nxt    = '0;
                wr_nxt    = '0;
                state_nxt = ST_RD;
              end else if (req_r == tsg_pkg::REQ_QUERY) begin
                ans_nxt = hitg_r[0] | hitg_r[1];
              end else begin
                scan_nxt[0] = sc0;
                scan_nxt[1] = sc1;
                // both slots: slot 2 only when slot 1 refused
                use1 = (slotn_r == 2'd2) || (slotn_r == 2'd0 && !gr0);
                if (slotn_r != 2'd2 && gr0) begin
                  scan_nxt[0] = grp_r;
                  hold_nxt[0] = now_r;
                end
                if (use1 && gr1) begin
                  scan_nxt[1] = grp_r;
                  hold_nxt[1] = now_r;
                end
                ans_nxt = (slotn_r != 2'd2 && gr0) || (use1 && gr1);
              end
            end
            default: ;
          endcase
        end
      end

      ST_PROC: begin
        remove = ((mode_r == tsg_pkg::WALK_DROP) && ev.group_hit) ||
                 ((mode_r == tsg_pkg::WALK_PURGE) && ev.expired);
        rd_nxt    = rd_r + FW'(1);
        state_nxt = ST_RD;
        if (!remove) begin
          we     = 1'b1;
          wr_nxt = wr_r + FW'(1);
          if (mode_r == tsg_pkg::WALK_RENEW && !renewed_r && ev.group_hit &&
              !rentry.fixed) begin
            wentry.deadline = ev.new_deadline;
            renewed_nxt     = 1'b1;
          end
          if (ev.group_hit && !ev.expired) hitg_nxt[ws_r] = 1'b1;
          if (ev.scan_hit && !ev.expired)  hits_nxt[ws_r] = 1'b1;
        end
      end

      ST_FIN: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          oans_nxt   = ans_r;
          osts_nxt   = sts_r;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= tsg_pkg::WALK_QUERY;
      req_r     <= tsg_pkg::REQ_NONE;
      fill_r[0] <= '0;
      fill_r[1] <= '0;
      rd_r      <= '0;
      wr_r      <= '0;
      ws_r      <= 1'b0;
      hitg_r    <= '0;
      hits_r    <= '0;
      renewed_r <= 1'b0;
      now_r     <= '0;
      scan_r[0] <= '0;
      scan_r[1] <= '0;
      single_r  <= 1'b0;
      holdsec_r <= tsg_pkg::HOLD_RESET;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      req_r     <= req_nxt;
      fill_r    <= fill_nxt;
      rd_r      <= rd_nxt;
      wr_r      <= wr_nxt;
      ws_r      <= ws_nxt;
      hitg_r    <= hitg_nxt;
      hits_r    <= hits_nxt;
      renewed_r <= renewed_nxt;
      now_r     <= now_nxt;
      scan_r    <= scan_nxt;
      single_r  <= single_nxt;
      holdsec_r <= holdsec_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r  <= hold_nxt;
    grp_r   <= grp_nxt;
    slotn_r <= slotn_nxt;
    tmo_r   <= tmo_nxt;
    stat_r  <= stat_nxt;
    ans_r   <= ans_nxt;
    sts_r   <= sts_nxt;
    oans_r  <= oans_nxt;
    osts_r  <= osts_nxt;
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= FILL_MAX) && (fill_r[1] <= FILL_MAX))
    else $error("slot fill count beyond table size");

  a_pack_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROC) |-> (wr_r <= rd_r) && (rd_r < fill_r[ws_r]))
    else $error("compaction write pointer passed read pointer");

  a_proc_return: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROC) |=> (state_r == ST_RD))
    else $error("entry step did not return to read");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");
`endif

endmodule

[rtl/tsg_ram.sv]
// generic single write port ram with registered read
module tsg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/tsg_eval.sv]
// per entry compare unit: expiry, group matches and renewed deadline
module tsg_eval (
  input  tsg_pkg::entry_t entry,
  input  logic [31:0]     now,
  input  logic [23:0]     req_group,
  input  logic [23:0]     scan_group,
  input  logic [15:0]     timeout,
  output tsg_pkg::eval_t  res
);
  always_comb begin
    res.expired   = !entry.fixed && (entry.lifetime != 16'd0) &&
                    ({1'b0, now} > entry.deadline);
    res.group_hit = (entry.group == req_group);
    res.scan_hit  = (entry.group == scan_group);
    // zero timeout means no deadline
    res.new_deadline = (timeout == 16'd0) ? 33'd0 :
                       ({1'b0, now} + {17'd0, timeout});
  end
endmodule

[dv/tsg_gate_checker.sv]
`timescale 1ns / 1ps
// checker for the talkgroup scan gate: table predictor and result comparison
module tsg_gate_checker
  import tsg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tsg_in_if.sink    in_mon,
  tsg_out_if.sink   out_mon,
  tsg_cfg_if.sink   cfg_mon,
  output int        fail_count,
  output int        pending_count,
  output int        grant_count
);

  localparam int N = ENTRIES_PER_SLOT_DEF;

  typedef struct packed {
    logic       answer;
    logic [1:0] status;
  } verdict_t;

  logic        tbl_valid [2][N];
  logic [23:0] tbl_group [2][N];
  logic [15:0] tbl_life  [2][N];
  logic [32:0] tbl_dead  [2][N];
  logic        tbl_fixed [2][N];
  logic [23:0] scan_grp  [2];
  logic [31:0] hold_t0   [2];
  logic [31:0] now_s;
  logic        single_on;
  logic [15:0] hold_len;
  verdict_t    verdict_q [$];

  function automatic bit stale(int s, int k);
    return !tbl_fixed[s][k] && tbl_life[s][k] != 0 && {1'b0, now_s} > tbl_dead[s][k];
  endfunction

  function automatic void compact(int s);
    int w;
    w = 0;
    for (int r = 0; r < N; r++) begin
      if (tbl_valid[s][r]) begin
        tbl_group[s][w] = tbl_group[s][r];
        tbl_life[s][w]  = tbl_life[s][r];
        tbl_dead[s][w]  = tbl_dead[s][r];
        tbl_fixed[s][w] = tbl_fixed[s][r];
        if (w != r) tbl_valid[s][r] = 0;
        tbl_valid[s][w] = 1;
        w++;
      end
    end
  endfunction

  function automatic int fill(int s);
    int n;
    n = 0;
    for (int k = 0; k < N; k++) n += tbl_valid[s][k];
    return n;
  endfunction

  function automatic bit live(int s, logic [23:0] g);
    for (int k = 0; k < N; k++)
      if (tbl_valid[s][k] && tbl_group[s][k] == g && !stale(s, k)) return 1;
    return 0;
  endfunction

  function automatic void sweep();
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < N; k++) if (tbl_valid[s][k] && stale(s, k)) tbl_valid[s][k] = 0;
      compact(s);
    end
    for (int s = 0; s < 2; s++)
      if (scan_grp[s] != 0 && !live(s, scan_grp[s])) scan_grp[s] = 0;
  endfunction

  function automatic bit try_slot(int s, logic [23:0] g);
    sweep();
    if (!live(s, g)) return 0;
    if (scan_grp[s] != 0) begin
      if (scan_grp[s] == g) begin
        hold_t0[s] = now_s;
        return 1;
      end
      if (now_s - hold_t0[s] < {16'd0, hold_len}) return 0;
    end
    scan_grp[s] = g;
    hold_t0[s] = now_s;
    return 1;
  endfunction

  function automatic logic [32:0] expiry(logic [15:0] t);
    return t == 0 ? 33'd0 : {1'b0, now_s} + t;
  endfunction

  function automatic verdict_t serve(req_t req, logic [23:0] g, logic [1:0] slot,
                                     logic [15:0] t, logic fix);
    verdict_t v;
    int s, k;
    bit good;
    v = '0;
    s = int'(slot) - 1;
    good = (slot == 1 || slot == 2);
    case (req)
      REQ_TICK: if (now_s != NOW_TOP) now_s++;
      REQ_ADD: begin
        if (!good) v.status = STS_SLOT;
        else if (g == CLEAR_GROUP) begin
          for (k = 0; k < N; k++) tbl_valid[s][k] = 0;
        end else begin
          if (single_on) begin
            for (k = 0; k < N; k++) tbl_valid[s][k] = 0;
            fix = 1;
          end
          for (k = 0; k < N; k++) if (tbl_valid[s][k] && tbl_group[s][k] == g) tbl_valid[s][k] = 0;
          compact(s);
          k = fill(s);
          if (k >= N) v.status = STS_FULL;
          else begin
            tbl_valid[s][k] = 1;
            tbl_group[s][k] = g;
            tbl_life[s][k]  = t;
            tbl_dead[s][k]  = expiry(t);
            tbl_fixed[s][k] = fix;
          end
        end
      end
      REQ_RENEW: begin
        if (!good) v.status = STS_SLOT;
        else
          for (k = 0; k < N; k++)
            if (tbl_valid[s][k] && tbl_group[s][k] == g && !tbl_fixed[s][k]) begin
              tbl_dead[s][k] = expiry(t);
              break;
            end
      end
      REQ_REMOVE: begin
        if (!good) v.status = STS_SLOT;
        else begin
          for (k = 0; k < N; k++) if (tbl_valid[s][k] && tbl_group[s][k] == g) tbl_valid[s][k] = 0;
          compact(s);
        end
      end
      REQ_CLEAR: begin
        for (k = 0; k < N; k++) begin
          tbl_valid[0][k] = 0;
          tbl_valid[1][k] = 0;
        end
        scan_grp[0] = 0;
        scan_grp[1] = 0;
      end
      REQ_ACCESS: begin
        if (slot == 0) v.answer = try_slot(0, g) || try_slot(1, g);
        else if (good) v.answer = try_slot(s, g);
        else v.status = STS_SLOT;
      end
      REQ_QUERY: v.answer = live(0, g) || live(1, g);
      default: ;
    endcase
    return v;
  endfunction

  assign pending_count = verdict_q.size();

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < N; k++) tbl_valid[s][k] = 0;
        scan_grp[s] = 0;
        hold_t0[s] = 0;
      end
      now_s = 0;
      single_on = 0;
      hold_len = HOLD_RESET;
      fail_count = 0;
      grant_count = 0;
      verdict_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_SINGLE_MODE) single_on = cfg_mon.data[0];
        else if (cfg_mon.index == CFG_HOLD_SECONDS) hold_len = cfg_mon.data;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result with nothing expected: answer %0d status %0d",
                 out_mon.answer, out_mon.status);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_mon.answer !== want.answer) begin
            $error("answer: expected %0d, got %0d", want.answer, out_mon.answer);
            fail_count++;
          end
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            fail_count++;
          end
          if (want.answer) grant_count++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        verdict_q.insert(verdict_q.size(),
                         serve(req_t'(in_mon.req_type), in_mon.group_id, in_mon.slot_num,
                               in_mon.timeout_seconds, in_mon.make_static));
    end
  end

endmodule

[dv/talkgroup_scan_gate_test.sv]
`timescale 1ns / 1ps
// testbench top: clock, reset, request and config stimulus, verdict
module talkgroup_scan_gate_test;
  import tsg_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   fails, pending, grants;
  int   idle_on_in = 1;   // random source gaps enabled
  int   idle_on_out = 1;  // random sink stalls enabled
  int   sent;

  tsg_in_if  in_ch ();
  tsg_out_if out_ch ();
  tsg_cfg_if cfg_ch ();

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  talkgroup_scan_gate i_dut (.clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
                             .cfg_ch(cfg_ch.sink));

  tsg_gate_checker i_chk (.clk, .rst_n, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
                          .cfg_mon(cfg_ch.sink), .fail_count(fails),
                          .pending_count(pending), .grant_count(grants));

  // small pool of groups so adds, renews and accesses hit each other often
  logic [23:0] pool [8] = '{24'd1, 24'd2, 24'd3, 24'd9, 24'hFFFFFF, 24'd4001, 24'd77, 24'd0};

  initial begin
    in_ch.valid = 0;
    in_ch.req_type = REQ_TICK;
    in_ch.group_id = 0;
    in_ch.slot_num = 0;
    in_ch.timeout_seconds = 0;
    in_ch.make_static = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_SINGLE_MODE;
    cfg_ch.data = 0;
  end

  // sink side: bursts of stall, and bursts of steady ready
  initial begin
    @(posedge clk);
    forever begin
      out_ch.ready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (idle_on_out && $urandom_range(0, 1)) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send(req_t r, logic [23:0] g, logic [1:0] sl, logic [15:0] t, logic fx);
    if (idle_on_in && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.req_type <= r;
    in_ch.group_id <= g;
    in_ch.slot_num <= sl;
    in_ch.timeout_seconds <= t;
    in_ch.make_static <= fx;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic go_quiet();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // every item gives a result, so no item is still walking the table here
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
  endtask

  task automatic random_item();
    int pick;
    logic [23:0] g;
    logic [15:0] t;
    pick = $urandom_range(0, 99);
    g = ($urandom_range(0, 9) == 0) ? 24'($urandom) : pool[$urandom_range(0, 7)];
    if ($urandom_range(0, 40) == 0) g = CLEAR_GROUP;
    case ($urandom_range(0, 5))
      0: t = 0;
      1: t = 16'hFFFF;
      2: t = 16'($urandom);
      default: t = 16'($urandom_range(1, 12));
    endcase
    if (pick < 25) send(REQ_TICK, 24'($urandom), 2'($urandom), 16'($urandom), 1'($urandom));
    else if (pick < 45) send(REQ_ADD, g, ($urandom_range(0, 15) == 0) ? 2'($urandom)
                                     : 2'($urandom_range(1, 2)), t, $urandom_range(0, 5) == 0);
    else if (pick < 52) send(REQ_RENEW, g, 2'($urandom), t, 1'($urandom));
    else if (pick < 58) send(REQ_REMOVE, g, 2'($urandom), t, 1'($urandom));
    else if (pick < 60) send(REQ_CLEAR, g, 2'($urandom), t, 1'($urandom));
    else if (pick < 85) send(REQ_ACCESS, g, 2'($urandom), t, 1'($urandom));
    else if (pick < 98) send(REQ_QUERY, g, 2'($urandom), t, 1'($urandom));
    else send(REQ_NONE, g, 2'($urandom), t, 1'($urandom));
  endtask

  initial begin
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, every request, bad slots, clear group, full table
    send(REQ_NONE, 24'hFFFFFF, 2'd3, 16'hFFFF, 1);
    send(REQ_ADD, 24'hFFFFFF, 2'd1, 16'hFFFF, 0);
    send(REQ_ADD, 24'd5, 2'd1, 16'd0, 0);
    send(REQ_ADD, 24'd5, 2'd0, 16'd3, 0);
    send(REQ_ADD, 24'd5, 2'd3, 16'd3, 0);
    send(REQ_RENEW, 24'd5, 2'd3, 16'd2, 0);
    send(REQ_REMOVE, 24'd5, 2'd0, 16'd2, 0);
    send(REQ_ACCESS, 24'd5, 2'd3, 0, 0);
    send(REQ_ADD, 24'd6, 2'd2, 16'd2, 0);
    send(REQ_ACCESS, 24'd6, 2'd0, 0, 0);
    send(REQ_ACCESS, 24'hFFFFFF, 2'd1, 0, 0);
    send(REQ_ACCESS, 24'd5, 2'd1, 0, 0);
    send(REQ_RENEW, 24'd6, 2'd2, 16'd0, 0);
    send(REQ_TICK, 0, 0, 0, 0);
    send(REQ_QUERY, 24'd6, 2'd1, 0, 0);
    send(REQ_ADD, 24'd0, 2'd2, 16'd1, 1);
    send(REQ_ACCESS, 24'd0, 2'd2, 0, 0);
    for (int i = 0; i < 17; i++) send(REQ_ADD, 24'(100 + i), 2'd1, 16'd9, 0);
    send(REQ_ADD, 24'd100, 2'd1, 16'd9, 0);
    send(REQ_ADD, CLEAR_GROUP, 2'd1, 0, 0);
    send(REQ_REMOVE, 24'd0, 2'd2, 0, 0);
    send(REQ_CLEAR, 0, 0, 0, 0);

    // sender holds off until the block has drained
    go_quiet();
    write_reg(CFG_SINGLE_MODE, 16'd1);
    write_reg(CFG_HOLD_SECONDS, 16'd0);
    repeat (150) random_item();

    go_quiet();
    write_reg(CFG_SINGLE_MODE, 16'd0);
    write_reg(CFG_HOLD_SECONDS, 16'hFFFF);
    repeat (250) random_item();

    go_quiet();
    write_reg(CFG_HOLD_SECONDS, 16'd3);
    repeat (400) random_item();

    // last stretch runs at full rate on both sides
    idle_on_in = 0;
    idle_on_out = 0;
    repeat (200) random_item();
    in_ch.valid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d items: all request kinds, bad slots, full table, both modes", sent);
    $display("hold times 0, 3, 5 and 65535; %0d grants or hits seen", grants);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // limit is several times over the worst case per item plus stalls
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
